### design/bgq_pkg.sv
// Shared types and constants for the beat grid quantizer.
// No dependencies; used by bgq_cell and beat_grid_quantizer.
`default_nettype none

package bgq_pkg;

   // field widths
   localparam int unsigned SLOT_W   = 10;
   localparam int unsigned TIME_W   = 24;
   localparam int unsigned POS_W    = 32;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned SCALED_W = 40;  // time * 44100
   localparam int unsigned POSK_W   = 42;  // position * 1000
   localparam int unsigned CMP_W    = 43;  // doubled position, signed compare width

   localparam int unsigned MAX_BEATS_DEF = 1024;
   localparam int unsigned CHAIN_LEN     = 2;

   localparam logic [15:0] SAMPLE_RATE = 16'd44100;
   localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // one table entry traveling down the chain
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [COUNT_W-1:0]  idx;
      logic [TIME_W-1:0]   time_ms;
      logic [SCALED_W-1:0] scaled;
      logic                p_ge;   // position >= entry
      logic                p_le;   // position <= entry
   } cell_type;

endpackage

`default_nettype wire

### design/bgq_cell.sv
// One cell of the entry chain: holds a table entry and its compare flags.
// Depends on bgq_pkg.
`default_nettype none

module bgq_cell (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire signed [bgq_pkg::POSK_W-1:0]     posk,
   input  bgq_pkg::cell_type                    cell_in,
   output bgq_pkg::cell_type                    cell_out
);

   bgq_pkg::cell_type cell_ff;
   bgq_pkg::cell_type cell_in_w;
   logic signed [bgq_pkg::POSK_W-1:0] scaled_s;

   // compare the entry against the scaled position on the way in
   always_comb begin
      scaled_s          = $signed({2'b00, cell_in.scaled});
      cell_in_w         = cell_in;
      cell_in_w.p_ge    = (posk >= scaled_s);
      cell_in_w.p_le    = (posk <= scaled_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in_w.valid;
      end
      cell_ff.last    <= cell_in_w.last;
      cell_ff.idx     <= cell_in_w.idx;
      cell_ff.time_ms <= cell_in_w.time_ms;
      cell_ff.scaled  <= cell_in_w.scaled;
      cell_ff.p_ge    <= cell_in_w.p_ge;
      cell_ff.p_le    <= cell_in_w.p_le;
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

### design/beat_grid_quantizer.sv
// Beat grid quantizer: a write stores one beat time, a query snaps a position to a beat.
// A query scans the active beats, one table read per cycle; an empty table skips the scan.
// One request at a time: a new request is accepted only in the idle state.
// The table read port feeds a chain of bgq_cell stages that compare each entry.
// Reset clears the beat count, control and output valid; the table is not cleared.
// Depends on bgq_pkg and bgq_cell.
`default_nettype none

module beat_grid_quantizer #(
   parameter int unsigned MAX_BEATS = bgq_pkg::MAX_BEATS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   // request: [9:0] beat_slot, [33:10] beat_time_ms, [65:34] sample_position, rest zero
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,
   input  wire         req_tuser,   // [0] req_type
   // response: [9:0] nearest_beat, [33:10] nearest_time_ms, rest zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // [0] found
   // beat count register
   input  wire         csr_wen,
   input  wire  [10:0] csr_wdata
);

   localparam int unsigned AW = (MAX_BEATS > 1) ? $clog2(MAX_BEATS) : 1;
   localparam int unsigned CW = bgq_pkg::COUNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_WAIT   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [CW-1:0] count_ff, n_ff, n_in, cnt_ff, cnt_in;
   logic signed [bgq_pkg::POS_W-1:0]  pos_ff;
   logic signed [bgq_pkg::POSK_W-1:0] posk_ff, posk_in;

   logic req_acc, wr_acc, q_acc;
   logic [bgq_pkg::SLOT_W-1:0] req_slot;
   logic [bgq_pkg::TIME_W-1:0] req_time;

   // table memory and read stage
   logic [bgq_pkg::TIME_W-1:0] mem [MAX_BEATS];
   logic [bgq_pkg::TIME_W-1:0] rd_time_ff, sc_time_ff;
   logic [CW-1:0]              rd_idx_ff, sc_idx_ff;
   logic                       rd_valid_ff, rd_last_ff, sc_valid_ff, sc_last_ff;
   logic [bgq_pkg::SCALED_W-1:0] sc_scaled_ff;
   logic issue;

   bgq_pkg::cell_type chain [bgq_pkg::CHAIN_LEN+1];

   // evaluator state
   logic below_ff, above_ff, hit_ff, done_ff;
   logic [CW-1:0] pick_idx_ff, last_idx_ff;
   logic [bgq_pkg::TIME_W-1:0] pick_time_ff, last_time_ff, first_time_ff;
   logic signed [bgq_pkg::CMP_W-1:0] twop, mid;
   logic in_iv;

   logic out_free;
   logic [bgq_pkg::SLOT_W-1:0] res_idx;
   logic [bgq_pkg::TIME_W-1:0] res_time;
   logic                       res_found;

   assign req_slot   = req_tdata[9:0];
   assign req_time   = req_tdata[33:10];
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign wr_acc     = req_acc && (req_tuser == bgq_pkg::REQ_WRITE);
   assign q_acc      = req_acc && (req_tuser == bgq_pkg::REQ_QUERY);
   assign out_free   = !rsp_tvalid || rsp_tready;

   // clamp the beat count to the table depth
   assign n_in = (32'(count_ff) > MAX_BEATS) ? CW'(MAX_BEATS) : count_ff;

   // beat count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wen) begin
         count_ff <= csr_wdata;
      end
   end

   // sequencer
   assign issue = (state_ff == S_SCAN);
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (q_acc) begin
               state_in = (n_in == '0) ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == n_ff - 1'b1) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (done_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      if (q_acc) begin
         n_ff   <= n_in;
         pos_ff <= $signed(req_tdata[65:34]);
      end
      posk_ff <= posk_in;
   end

   assign posk_in = pos_ff * $signed({1'b0, bgq_pkg::MS_PER_SEC});

   // table write and registered read
   always_ff @(posedge clock) begin
      if (wr_acc && (32'(req_slot) < MAX_BEATS)) begin
         mem[AW'(req_slot)] <= req_time;
      end
      rd_time_ff <= mem[AW'(cnt_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         sc_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         sc_valid_ff <= rd_valid_ff;
      end
      rd_idx_ff    <= cnt_ff;
      rd_last_ff   <= (cnt_ff == n_ff - 1'b1);
      sc_idx_ff    <= rd_idx_ff;
      sc_last_ff   <= rd_last_ff;
      sc_time_ff   <= rd_time_ff;
      sc_scaled_ff <= rd_time_ff * bgq_pkg::SAMPLE_RATE;
   end

   // entry chain
   always_comb begin
      chain[0]         = '0;
      chain[0].valid   = sc_valid_ff;
      chain[0].last    = sc_last_ff;
      chain[0].idx     = sc_idx_ff;
      chain[0].time_ms = sc_time_ff;
      chain[0].scaled  = sc_scaled_ff;
   end

   for (genvar g = 0; g < bgq_pkg::CHAIN_LEN; g++) begin : g_cell
      bgq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .posk     (posk_ff),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // interval test on the current entry and its predecessor
   assign twop  = $signed({posk_ff, 1'b0});
   assign mid   = $signed({2'b00, ({1'b0, chain[1].scaled} + {1'b0, chain[2].scaled})});
   assign in_iv = chain[1].valid && chain[2].valid && (chain[1].idx != '0)
                  && chain[2].p_ge && chain[1].p_le;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (q_acc) begin
         done_ff <= 1'b0;
      end else if (chain[1].valid && chain[1].last) begin
         done_ff <= 1'b1;
      end
      if (q_acc) begin
         below_ff <= 1'b0;
         above_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else if (chain[1].valid) begin
         if (chain[1].idx == '0) begin
            below_ff      <= !chain[1].p_ge;
            first_time_ff <= chain[1].time_ms;
         end
         if (chain[1].last) begin
            above_ff     <= !chain[1].p_le;
            last_idx_ff  <= chain[1].idx;
            last_time_ff <= chain[1].time_ms;
         end
         // first interval that holds the position wins
         if (in_iv && !hit_ff) begin
            hit_ff <= 1'b1;
            if (twop < mid) begin
               pick_idx_ff  <= chain[2].idx;
               pick_time_ff <= chain[2].time_ms;
            end else begin
               pick_idx_ff  <= chain[1].idx;
               pick_time_ff <= chain[1].time_ms;
            end
         end
      end
   end

   // final choice
   always_comb begin
      res_found = 1'b1;
      res_idx   = bgq_pkg::SLOT_W'(last_idx_ff);
      res_time  = last_time_ff;
      if (n_ff == '0) begin
         res_found = 1'b0;
         res_idx   = '0;
         res_time  = '0;
      end else if (below_ff) begin
         res_idx  = '0;
         res_time = first_time_ff;
      end else if (above_ff) begin
         res_idx  = bgq_pkg::SLOT_W'(last_idx_ff);
         res_time = last_time_ff;
      end else if (hit_ff) begin
         res_idx  = bgq_pkg::SLOT_W'(pick_idx_ff);
         res_time = pick_time_ff;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if ((state_ff == S_FINISH) && out_free) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_tdata <= {6'b0, res_time, res_idx};
         rsp_tuser <= res_found;
      end
   end

   // checks
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("not-found response carries nonzero data");

   a_chain_busy: assert property (@(posedge clock) disable iff (reset)
      chain[1].valid |-> state_ff == S_WAIT || state_ff == S_SCAN)
      else $error("chain active outside a scan");

   a_finish_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT && state_in == S_FINISH |-> done_ff)
      else $error("scan finished before the last entry");

endmodule

`default_nettype wire
